FILE: hw/rtl/iabr_pkg.sv
// Shared types and constants of the integer ALU / branch resolver.
// No dependencies; imported by every module of the block.
`default_nettype none

package iabr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int TAG_BITS   = 4;
  localparam int SHIFT_BITS = $clog2(DATA_WIDTH);

  // Stream widths: fields packed from bit 0, padded to whole bytes.
  localparam int IN_TDATA_W  = ((3*DATA_WIDTH + TAG_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + TAG_BITS + 7) / 8) * 8;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_DIV  = 5'd3,
    OP_AND  = 5'd4,
    OP_OR   = 5'd5,
    OP_BEQ  = 5'd6,
    OP_BNE  = 5'd7,
    OP_BGT  = 5'd8,
    OP_BGE  = 5'd9,
    OP_BLT  = 5'd10,
    OP_BLE  = 5'd11,
    OP_LI   = 5'd12,
    OP_BEQZ = 5'd13,
    OP_BNEZ = 5'd14,
    OP_BGTZ = 5'd15,
    OP_BLEZ = 5'd16,
    OP_MOVE = 5'd17,
    OP_NEG  = 5'd18,
    OP_NOT  = 5'd19,
    OP_SLL  = 5'd20,
    OP_SLR  = 5'd21,
    OP_JUMP = 5'd22
  } op_t;

  typedef enum logic [1:0] {
    KIND_RESULT    = 2'd0,
    KIND_NOT_TAKEN = 2'd1,
    KIND_TAKEN     = 2'd2
  } kind_t;

  typedef logic [DATA_WIDTH-1:0] data_t;

  // One stage of the divider chain; non-divide items ride along in res.
  typedef struct packed {
    logic                valid;
    logic                is_div;
    logic                neg_q;
    logic                dsr_zero;
    data_t               rem;
    data_t               dvd;     // dividend bits in, quotient bits out
    data_t               dsr;
    data_t               res;
    kind_t               kind;
    logic [TAG_BITS-1:0] tag;
  } stage_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iabr_front.sv
// Decode and registered ALU stage; sets up the divider chain.
// Depends on iabr_pkg.
`default_nettype none

module iabr_front
  import iabr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [4:0]          opcode,
  input  wire data_t               op_a,
  input  wire data_t               op_b,
  input  wire data_t               target,
  input  wire logic [TAG_BITS-1:0] tag,
  output stage_t                   stage_r
);

  stage_t                stage_nxt;
  data_t                 prod;
  data_t                 mag_a, mag_b, shl, shr_mag, shr;
  logic [SHIFT_BITS-1:0] sh_n;
  logic                  b_le0, b_big, a_zero, lt_ab, lt_ba;
  logic                  is_br, taken;
  data_t                 res;

  always_comb begin
    // Low half of the product is the same for signed and unsigned operands.
    prod    = op_a * op_b;
    mag_a   = op_a[DATA_WIDTH-1] ? (~op_a + 1'b1) : op_a;
    mag_b   = op_b[DATA_WIDTH-1] ? (~op_b + 1'b1) : op_b;
    sh_n    = op_b[SHIFT_BITS-1:0];
    b_le0   = op_b[DATA_WIDTH-1] || (op_b == '0);
    b_big   = (op_b >= data_t'(DATA_WIDTH));
    shl     = op_a << sh_n;
    shr_mag = mag_a >> sh_n;
    shr     = op_a[DATA_WIDTH-1] ? (~shr_mag + 1'b1) : shr_mag;
    a_zero  = (op_a == '0);
    lt_ab   = $signed(op_a) < $signed(op_b);
    lt_ba   = $signed(op_b) < $signed(op_a);
    is_br   = 1'b1;
    taken   = 1'b0;
    res     = '0;
    case (op_t'(opcode))
      OP_ADD:  begin is_br = 1'b0; res = op_a + op_b; end
      OP_SUB:  begin is_br = 1'b0; res = op_a - op_b; end
      OP_MUL:  begin is_br = 1'b0; res = prod; end
      OP_DIV:  is_br = 1'b0;
      OP_AND:  begin is_br = 1'b0; res = op_a & op_b; end
      OP_OR:   begin is_br = 1'b0; res = op_a | op_b; end
      OP_BEQ:  taken = (op_a == op_b);
      OP_BNE:  taken = (op_a != op_b);
      OP_BGT:  taken = lt_ba;
      OP_BGE:  taken = !lt_ab;
      OP_BLT:  taken = lt_ab;
      OP_BLE:  taken = !lt_ba;
      OP_LI:   begin is_br = 1'b0; res = op_a; end
      OP_BEQZ: taken = a_zero;
      OP_BNEZ: taken = !a_zero;
      OP_BGTZ: taken = !a_zero && !op_a[DATA_WIDTH-1];
      OP_BLEZ: taken = a_zero || op_a[DATA_WIDTH-1];
      OP_MOVE: begin is_br = 1'b0; res = op_a; end
      OP_NEG:  begin is_br = 1'b0; res = ~op_a + 1'b1; end
      OP_NOT:  begin is_br = 1'b0; res = data_t'(a_zero); end
      OP_SLL:  begin
        is_br = 1'b0;
        res   = b_le0 ? op_a : (b_big ? '0 : shl);
      end
      OP_SLR:  begin
        is_br = 1'b0;
        res   = b_le0 ? op_a : (b_big ? '0 : shr);
      end
      OP_JUMP: taken = 1'b1;
      default: is_br = 1'b0;
    endcase

    stage_nxt.valid    = in_valid;
    stage_nxt.is_div   = (op_t'(opcode) == OP_DIV);
    stage_nxt.neg_q    = op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
    stage_nxt.dsr_zero = (op_b == '0);
    stage_nxt.rem      = '0;
    stage_nxt.dvd      = mag_a;
    stage_nxt.dsr      = mag_b;
    stage_nxt.res      = is_br ? target : res;
    stage_nxt.kind     = is_br ? (taken ? KIND_TAKEN : KIND_NOT_TAKEN) : KIND_RESULT;
    stage_nxt.tag      = tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
    if (en) begin
      stage_r.is_div   <= stage_nxt.is_div;
      stage_r.neg_q    <= stage_nxt.neg_q;
      stage_r.dsr_zero <= stage_nxt.dsr_zero;
      stage_r.rem      <= stage_nxt.rem;
      stage_r.dvd      <= stage_nxt.dvd;
      stage_r.dsr      <= stage_nxt.dsr;
      stage_r.res      <= stage_nxt.res;
      stage_r.kind     <= stage_nxt.kind;
      stage_r.tag      <= stage_nxt.tag;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/iabr_cell.sv
// One restoring-division cell: one quotient bit per stage.
// Depends on iabr_pkg.
`default_nettype none

module iabr_cell
  import iabr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire stage_t prev,
  output stage_t      stage_r
);

  stage_t              stage_nxt;
  logic [DATA_WIDTH:0] shifted, trial;

  always_comb begin
    shifted   = {prev.rem, prev.dvd[DATA_WIDTH-1]};
    trial     = shifted - {1'b0, prev.dsr};
    stage_nxt = prev;
    if (!trial[DATA_WIDTH]) begin
      stage_nxt.rem = trial[DATA_WIDTH-1:0];
    end else begin
      stage_nxt.rem = shifted[DATA_WIDTH-1:0];
    end
    stage_nxt.dvd = {prev.dvd[DATA_WIDTH-2:0], !trial[DATA_WIDTH]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
    if (en) begin
      stage_r.is_div   <= stage_nxt.is_div;
      stage_r.neg_q    <= stage_nxt.neg_q;
      stage_r.dsr_zero <= stage_nxt.dsr_zero;
      stage_r.rem      <= stage_nxt.rem;
      stage_r.dvd      <= stage_nxt.dvd;
      stage_r.dsr      <= stage_nxt.dsr;
      stage_r.res      <= stage_nxt.res;
      stage_r.kind     <= stage_nxt.kind;
      stage_r.tag      <= stage_nxt.tag;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/integer_alu_branch_resolver_core.sv
// Top level of the integer ALU / branch resolver: front stage, divider
// cell chain and output register. Depends on iabr_pkg, iabr_front, iabr_cell.
//
// Usage:
//  - Input channel in_*: one reservation-station entry per item
//    (opcode in in_tuser; operands, branch target, station tag in in_tdata).
//  - Output channel out_*: one broadcast per item (kind in out_tuser,
//    value and tag in out_tdata), in the order the items were accepted.
//  - Pipeline for every opcode: one front stage (ALU, multiplier, branch
//    compare), one divider cell per quotient bit, and the output register.
//  - Throughput: one item per cycle unless stalled; all stages move together.
//  - A stall on out_tready freezes the whole pipe; in_tready drops in the
//    same cycle and rises again as soon as the output register drains.
//  - Reset clears all valid bits; no items are in flight afterwards.
//  - Division truncates toward zero; a zero divisor yields 0.
`default_nettype none

module integer_alu_branch_resolver_core
  import iabr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // opcode[4:0]
  input  wire logic [4:0]             in_tuser,
  // first_operand[31:0], second_operand[63:32], branch_target[95:64],
  // station_tag[99:96], zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // signal_kind[1:0]
  output logic [1:0]                  out_tuser,
  // value[31:0], result_tag[35:32], zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int A_LO = 0;
  localparam int B_LO = A_LO + DATA_WIDTH;
  localparam int T_LO = B_LO + DATA_WIDTH;
  localparam int G_LO = T_LO + DATA_WIDTH;

  logic   en;
  stage_t chain [DATA_WIDTH+1];
  data_t  quot, val;

  logic                out_valid_r;
  kind_t               out_kind_r;
  data_t               out_val_r;
  logic [TAG_BITS-1:0] out_tag_r;

  // Whole pipe moves whenever the output register is free or draining.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  iabr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_tvalid),
    .opcode  (in_tuser),
    .op_a    (in_tdata[B_LO-1:A_LO]),
    .op_b    (in_tdata[T_LO-1:B_LO]),
    .target  (in_tdata[G_LO-1:T_LO]),
    .tag     (in_tdata[G_LO+TAG_BITS-1:G_LO]),
    .stage_r (chain[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    iabr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .prev   (chain[i]),
      .stage_r(chain[i+1])
    );
  end

  // Sign fix of the quotient; zero divisor forces 0.
  always_comb begin
    quot = chain[DATA_WIDTH].neg_q ? (~chain[DATA_WIDTH].dvd + 1'b1)
                                   : chain[DATA_WIDTH].dvd;
    if (chain[DATA_WIDTH].dsr_zero) begin
      quot = '0;
    end
    val = chain[DATA_WIDTH].is_div ? quot : chain[DATA_WIDTH].res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[DATA_WIDTH].valid;
    end
    if (en) begin
      out_kind_r <= chain[DATA_WIDTH].kind;
      out_val_r  <= val;
      out_tag_r  <= chain[DATA_WIDTH].tag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = OUT_TDATA_W'({out_tag_r, out_val_r});

  // Stalled pipe must not advance the chain.
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(chain[DATA_WIDTH]))
    else $error("divider chain moved during stall");

  // Branch broadcasts never come from the divider path.
  a_div_kind: assert property (@(posedge clk) disable iff (!rst_n)
    chain[DATA_WIDTH].valid && chain[DATA_WIDTH].is_div
      |-> chain[DATA_WIDTH].kind == KIND_RESULT)
    else $error("divide item carries branch kind");

  // Only the three defined kinds are broadcast.
  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r == KIND_RESULT || out_kind_r == KIND_NOT_TAKEN
                     || out_kind_r == KIND_TAKEN))
    else $error("illegal broadcast kind");

  // Input ready tracks the output register.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_valid_r || out_tready))
    else $error("input ready out of step with output");

endmodule

`default_nettype wire
